// ===== hw/rtl/fir_reverb_wet_dry_mixer_unit_defines.svh =====
// Assertion macros shared by the reverb mixer RTL.
`ifndef FIR_REVERB_WET_DRY_MIXER_UNIT_DEFINES_SVH
`define FIR_REVERB_WET_DRY_MIXER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FWM_ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fwm assertion failed");
`define FWM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("fwm assertion failed");
`else
`define FWM_ASSERT_PROP(lbl, clk, rst, prop)
`define FWM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/fwm_pkg.sv =====
`timescale 1ns / 1ps
package fwm_pkg;

   localparam int COEF_BITS = 16;
   localparam int COEF_FRAC = 15;
   localparam int GAIN_FRAC = 8;
   localparam int GAIN_BITS = 9;
   localparam int INDEX_BITS = 8;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_DIRECT_LEVEL = 2'd0;
   localparam csr_index_type CSR_REVERB_LEVEL = 2'd1;
   localparam csr_index_type CSR_ENABLE       = 2'd2;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

endpackage

// ===== hw/rtl/fwm_ram.sv =====
`timescale 1ns / 1ps
module fwm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/fir_reverb_wet_dry_mixer_unit.sv =====
`timescale 1ns / 1ps
// A sample word with enable high raises rsp_tvalid after these steps in order: one load,
// TAPS multiply-accumulate issues over both RAMs, a drain of the read and product stages, two mix steps and the output.
// With enable low the sample goes straight to the output step; a coefficient word is written as it is accepted.
// req_tready returns together with rsp_tvalid as the result is registered (later while a held result waits),
// so a new sample word is taken only once the result of the last one has been registered.
// After a synchronous reset both RAMs are cleared, address by address, before req_tready rises.
`include "fir_reverb_wet_dry_mixer_unit_defines.svh"
module fir_reverb_wet_dry_mixer_unit #(
   parameter int TAPS        = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // sample, coef_index, coef_value
   input  logic [((SAMPLE_BITS+fwm_pkg::INDEX_BITS+fwm_pkg::COEF_BITS+7)/8)*8-1:0]
                                                        req_tdata,
   // kind
   input  logic                                         req_tuser,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // out_sample
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]             rsp_tdata,
   // clipped
   output logic                                         rsp_tuser,
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  fwm_pkg::csr_index_type                       csr_index,
   input  logic [fwm_pkg::GAIN_BITS-1:0]                csr_data
);

   import fwm_pkg::*;

   localparam int AW     = $clog2(TAPS);
   localparam int RSP_W  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + AW;
   localparam int WET_W  = ACC_W - COEF_FRAC;
   localparam int MIX_W  = WET_W + GAIN_BITS + 2;
   localparam int Y_W    = MIX_W - GAIN_FRAC;
   localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_MAC, ST_MIX_DRY, ST_MIX_WET, ST_EMIT
   } state_type;

   state_type                      state_ff, state_in;
   logic [AW-1:0]                  clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]                  wp_ff, wp_in;
   logic [AW-1:0]                  rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]                  iss_cnt_ff, iss_cnt_in;
   logic                           iss_act_ff, iss_act_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic                           prod_vld_ff, prod_vld_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [MIX_W-1:0]        mix_ff, mix_in;
   logic signed [SAMPLE_BITS-1:0]  x_ff, x_in;
   logic                           bypass_ff, bypass_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic [SAMPLE_BITS-1:0]         out_ff, out_in;
   logic                           clip_ff, clip_in;
   logic [GAIN_BITS-1:0]           direct_lvl_ff, reverb_lvl_ff;
   logic                           enable_ff;

   logic signed [SAMPLE_BITS-1:0]  req_sample;
   logic [INDEX_BITS-1:0]          req_coef_index;
   logic signed [COEF_BITS-1:0]    req_coef_value;
   logic                           accept;

   logic                           dl_wr_en, cf_wr_en;
   logic [AW-1:0]                  dl_wr_addr, cf_wr_addr;
   logic [SAMPLE_BITS-1:0]         dl_wr_data;
   logic [COEF_BITS-1:0]           cf_wr_data;
   logic [SAMPLE_BITS-1:0]         dl_rd_data;
   logic [COEF_BITS-1:0]           cf_rd_data;

   logic signed [WET_W-1:0]        wet;
   logic signed [Y_W-1:0]          y;
   logic [Y_W-SAMPLE_BITS:0]       y_top;
   logic                           out_free;

   assign req_sample     = req_tdata[SAMPLE_BITS-1:0];
   assign req_coef_index = req_tdata[SAMPLE_BITS+INDEX_BITS-1:SAMPLE_BITS];
   assign req_coef_value = req_tdata[SAMPLE_BITS+INDEX_BITS+COEF_BITS-1:
                                     SAMPLE_BITS+INDEX_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_W'(out_ff);
   assign rsp_tuser  = clip_ff;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   assign wet   = WET_W'(acc_ff >>> COEF_FRAC);
   assign y     = Y_W'(mix_ff >>> GAIN_FRAC);
   assign y_top = y[Y_W-1:SAMPLE_BITS-1];

   always_comb begin
      dl_wr_en   = 1'b0;
      dl_wr_addr = wp_ff;
      dl_wr_data = x_ff;
      cf_wr_en   = 1'b0;
      cf_wr_addr = AW'(req_coef_index);
      cf_wr_data = req_coef_value;
      if (state_ff == ST_CLEAR) begin
         dl_wr_en   = 1'b1;
         dl_wr_addr = clr_cnt_ff;
         dl_wr_data = '0;
         cf_wr_en   = 1'b1;
         cf_wr_addr = clr_cnt_ff;
         cf_wr_data = '0;
      end else if (state_ff == ST_LOAD) begin
         dl_wr_en = 1'b1;
      end else if (accept && req_tuser == KIND_COEF && 32'(req_coef_index) < TAPS) begin
         cf_wr_en = 1'b1;
      end
   end

   fwm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAPS)) u_delay_ram (
      .clock   (clock),
      .wr_en   (dl_wr_en),
      .wr_addr (dl_wr_addr),
      .wr_data (dl_wr_data),
      .rd_addr (rd_ptr_ff),
      .rd_data (dl_rd_data)
   );

   fwm_ram #(.WIDTH(COEF_BITS), .DEPTH(TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (cf_wr_en),
      .wr_addr (cf_wr_addr),
      .wr_data (cf_wr_data),
      .rd_addr (iss_cnt_ff),
      .rd_data (cf_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      wp_in       = wp_ff;
      rd_ptr_in   = rd_ptr_ff;
      iss_cnt_in  = iss_cnt_ff;
      iss_act_in  = iss_act_ff;
      rd_vld_in   = iss_act_ff;
      prod_vld_in = rd_vld_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      mix_in      = mix_ff;
      x_in        = x_ff;
      bypass_in   = bypass_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      out_in      = out_ff;
      clip_in     = clip_ff;

      if (rd_vld_ff) begin
         prod_in = PROD_W'($signed(cf_rd_data) * $signed(dl_rd_data));
      end
      if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(TAPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_tuser == KIND_SAMPLE) begin
               x_in      = req_sample;
               bypass_in = !enable_ff;
               state_in  = enable_ff ? ST_LOAD : ST_EMIT;
            end
         end
         ST_LOAD: begin
            acc_in     = '0;
            rd_ptr_in  = wp_ff;
            iss_cnt_in = '0;
            iss_act_in = 1'b1;
            wp_in      = (wp_ff == AW'(TAPS - 1)) ? '0 : wp_ff + 1'b1;
            state_in   = ST_MAC;
         end
         ST_MAC: begin
            if (iss_act_ff) begin
               iss_cnt_in = iss_cnt_ff + 1'b1;
               rd_ptr_in  = (rd_ptr_ff == '0) ? AW'(TAPS - 1) : rd_ptr_ff - 1'b1;
               if (iss_cnt_ff == AW'(TAPS - 1)) begin
                  iss_act_in = 1'b0;
               end
            end else if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_MIX_DRY;
            end
         end
         ST_MIX_DRY: begin
            mix_in   = MIX_W'($signed({1'b0, direct_lvl_ff}) * x_ff);
            state_in = ST_MIX_WET;
         end
         ST_MIX_WET: begin
            mix_in   = mix_ff + MIX_W'($signed({1'b0, reverb_lvl_ff}) * wet);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
               if (bypass_ff) begin
                  out_in  = x_ff;
                  clip_in = 1'b0;
               end else if (y_top == '0 || y_top == '1) begin
                  out_in  = y[SAMPLE_BITS-1:0];
                  clip_in = 1'b0;
               end else begin
                  out_in  = y[Y_W-1] ? SAT_MIN : SAT_MAX;
                  clip_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         wp_ff         <= '0;
         iss_act_ff    <= 1'b0;
         rd_vld_ff     <= 1'b0;
         prod_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         direct_lvl_ff <= GAIN_BITS'(256);
         reverb_lvl_ff <= '0;
         enable_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         wp_ff       <= wp_in;
         iss_act_ff  <= iss_act_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= prod_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIRECT_LEVEL: direct_lvl_ff <= csr_data;
               CSR_REVERB_LEVEL: reverb_lvl_ff <= csr_data;
               CSR_ENABLE:       enable_ff     <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
      rd_ptr_ff  <= rd_ptr_in;
      iss_cnt_ff <= iss_cnt_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      mix_ff     <= mix_in;
      x_ff       <= x_in;
      bypass_ff  <= bypass_in;
      out_ff     <= out_in;
      clip_ff    <= clip_in;
   end

   `FWM_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> !req_tready)
   `FWM_ASSERT_PROP(a_sample_blocks, clock, reset,
      (req_tvalid && req_tready && req_tuser == KIND_SAMPLE) |=> !req_tready)
   `FWM_ASSERT_PROP(a_clip_at_rail, clock, reset,
      (rsp_tvalid && rsp_tuser) |-> (out_ff == SAT_MAX || out_ff == SAT_MIN))

endmodule
